// File: rtl/core/signature_record_extractor_core_assert.svh
// Assertion macros for the signature record extractor core.
// Relies on clk and rst being in scope where the macros are used.
`ifndef SIGNATURE_RECORD_EXTRACTOR_CORE_ASSERT_SVH
`define SIGNATURE_RECORD_EXTRACTOR_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Condition that must hold on every clock edge out of reset.
`define SRE_ASSERT(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("sre assertion failed");
// Condition in one cycle implies a consequence in the next.
`define SRE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sre assertion failed");
`else
`define SRE_ASSERT(label, cond)
`define SRE_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// File: rtl/core/sre_pkg.sv
// Shared types and constants for the signature record extractor.
// No dependencies.
`timescale 1ns / 1ps

package sre_pkg;

  localparam int ADDR_BITS = 40;
  localparam int WORD_IDX_BITS = ADDR_BITS - 3;
  localparam int PADDR_BITS = 6;

  // Register indexes (byte address = 8 * index)
  localparam logic [2:0] REG_MAGIC        = 3'd0;
  localparam logic [2:0] REG_STRIDE       = 3'd1;
  localparam logic [2:0] REG_PID_OFF      = 3'd2;
  localparam logic [2:0] REG_PARENT_OFF   = 3'd3;
  localparam logic [2:0] REG_NAME_OFF     = 3'd4;
  localparam logic [2:0] REG_RECORD_WORDS = 3'd5;

  localparam logic [63:0] MAGIC_RESET        = 64'h0000_0000_0058_0003;
  localparam logic [3:0]  STRIDE_RESET       = 4'd2;
  localparam logic [7:0]  PID_OFF_RESET      = 8'd48;
  localparam logic [7:0]  PARENT_OFF_RESET   = 8'd82;
  localparam logic [7:0]  NAME_OFF_RESET     = 8'd92;
  localparam logic [7:0]  RECORD_WORDS_RESET = 8'd154;

  typedef struct packed {
    logic [63:0] magic_word;
    logic [3:0]  scan_stride_words;
    logic [7:0]  pid_word_offset;
    logic [7:0]  parent_word_offset;
    logic [7:0]  name_word_offset;
    logic [7:0]  record_words;
  } sre_cfg_t;

  typedef struct packed {
    logic [ADDR_BITS-1:0] record_address;
    logic [31:0]          process_id;
    logic [31:0]          parent_id;
    logic [63:0]          name_low;
    logic [63:0]          name_high;
  } sre_result_t;

  typedef struct packed {
    logic       in_record;
    logic [7:0] record_offset;
    logic [2:0] stride_phase;
  } sre_status_t;

endpackage

// File: rtl/core/sre_cfg_regs.sv
// APB-style configuration registers of the signature record extractor.
// Depends on sre_pkg.
`timescale 1ns / 1ps

module sre_cfg_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [sre_pkg::PADDR_BITS-1:0]  paddr,
  input  logic [63:0]                     pwdata,
  output logic [63:0]                     prdata,
  output logic                            pready,
  output sre_pkg::sre_cfg_t               cfg
);
  import sre_pkg::*;

  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[5:3];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.magic_word         <= MAGIC_RESET;
      cfg.scan_stride_words  <= STRIDE_RESET;
      cfg.pid_word_offset    <= PID_OFF_RESET;
      cfg.parent_word_offset <= PARENT_OFF_RESET;
      cfg.name_word_offset   <= NAME_OFF_RESET;
      cfg.record_words       <= RECORD_WORDS_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_MAGIC:        cfg.magic_word         <= pwdata;
        REG_STRIDE:       cfg.scan_stride_words  <= pwdata[3:0];
        REG_PID_OFF:      cfg.pid_word_offset    <= pwdata[7:0];
        REG_PARENT_OFF:   cfg.parent_word_offset <= pwdata[7:0];
        REG_NAME_OFF:     cfg.name_word_offset   <= pwdata[7:0];
        REG_RECORD_WORDS: cfg.record_words       <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_MAGIC:        prdata = cfg.magic_word;
      REG_STRIDE:       prdata = {60'd0, cfg.scan_stride_words};
      REG_PID_OFF:      prdata = {56'd0, cfg.pid_word_offset};
      REG_PARENT_OFF:   prdata = {56'd0, cfg.parent_word_offset};
      REG_NAME_OFF:     prdata = {56'd0, cfg.name_word_offset};
      REG_RECORD_WORDS: prdata = {56'd0, cfg.record_words};
      default:          prdata = 64'd0;
    endcase
  end

endmodule

// File: rtl/core/sre_scan.sv
// Scan state, signature compare and field capture for one image word.
// Depends on sre_pkg.
`timescale 1ns / 1ps

module sre_scan (
  input  logic                  clk,
  input  logic                  rst,
  input  sre_pkg::sre_cfg_t     cfg,
  input  logic [63:0]           word,
  input  logic                  step,
  output logic                  res_valid,
  output sre_pkg::sre_result_t  res,
  output sre_pkg::sre_status_t  status
);
  import sre_pkg::*;

  logic [WORD_IDX_BITS-1:0] word_count, word_count_next;
  logic                     in_record, in_record_next;
  logic [2:0]               stride_phase, stride_phase_next;
  logic [7:0]               record_offset, record_offset_next;
  logic [WORD_IDX_BITS-1:0] record_start, record_start_next;
  logic [31:0]              held_pid, held_pid_next;
  logic [31:0]              held_parent, held_parent_next;
  logic [63:0]              held_name_low, held_name_low_next;

  logic [3:0] stride_eff;
  logic [3:0] phase_inc;
  logic [8:0] off_inc;
  logic [8:0] name_high_off;

  always_comb begin
    // out-of-range strides clamp to 1..8
    if (cfg.scan_stride_words == 4'd0)     stride_eff = 4'd1;
    else if (cfg.scan_stride_words > 4'd8) stride_eff = 4'd8;
    else                                   stride_eff = cfg.scan_stride_words;

    phase_inc     = {1'b0, stride_phase} + 4'd1;
    off_inc       = {1'b0, record_offset} + 9'd1;
    name_high_off = {1'b0, cfg.name_word_offset} + 9'd1;

    word_count_next    = word_count + WORD_IDX_BITS'(1);
    in_record_next     = in_record;
    stride_phase_next  = stride_phase;
    record_offset_next = record_offset;
    record_start_next  = record_start;
    held_pid_next      = held_pid;
    held_parent_next   = held_parent;
    held_name_low_next = held_name_low;
    res_valid          = 1'b0;

    if (!in_record) begin
      if (stride_phase == 3'd0) begin
        if (word == cfg.magic_word) begin
          record_start_next = word_count;
          // one-word records end at once
          if (cfg.record_words > 8'd1) begin
            in_record_next     = 1'b1;
            record_offset_next = 8'd1;
          end
        end else begin
          stride_phase_next = (stride_eff > 4'd1) ? 3'd1 : 3'd0;
        end
      end else begin
        stride_phase_next = (phase_inc >= stride_eff) ? 3'd0 : phase_inc[2:0];
      end
    end else begin
      if (record_offset == cfg.pid_word_offset)    held_pid_next      = word[31:0];
      if (record_offset == cfg.parent_word_offset) held_parent_next   = word[31:0];
      if (record_offset == cfg.name_word_offset)   held_name_low_next = word;
      res_valid = ({1'b0, record_offset} == name_high_off);
      if (off_inc >= {1'b0, cfg.record_words}) begin
        in_record_next     = 1'b0;
        stride_phase_next  = 3'd0;
        record_offset_next = 8'd0;
      end else begin
        record_offset_next = off_inc[7:0];
      end
    end

    res.record_address = {record_start, 3'b000};
    res.process_id     = held_pid_next;
    res.parent_id      = held_parent_next;
    res.name_low       = held_name_low_next;
    res.name_high      = word;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_count    <= '0;
      in_record     <= 1'b0;
      stride_phase  <= 3'd0;
      record_offset <= 8'd0;
    end else if (step) begin
      word_count    <= word_count_next;
      in_record     <= in_record_next;
      stride_phase  <= stride_phase_next;
      record_offset <= record_offset_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      record_start  <= record_start_next;
      held_pid      <= held_pid_next;
      held_parent   <= held_parent_next;
      held_name_low <= held_name_low_next;
    end
  end

  assign status.in_record     = in_record;
  assign status.record_offset = record_offset;
  assign status.stride_phase  = stride_phase;

endmodule

// File: rtl/core/signature_record_extractor_core.sv
// Top level of the signature record extractor core.
// Depends on sre_pkg, sre_cfg_regs, sre_scan and the assertion macro header.
`timescale 1ns / 1ps
//
// Usage notes
// - Input channel: image_word with image_valid / image_ready, one 64-bit
//   little-endian word of the memory image per item, in address order.
// - Output channel: record_valid / record_ready with record_address,
//   process_id, parent_id, name_low and name_high; one item per record whose
//   second name word lies inside the record.
// - Config: APB-style port, 64-bit registers at byte address 8 * index;
//   write only while the block is idle. pready is tied high.
// - Path: an accepted item waits in the input register and is tested there;
//   its result (if any) is loaded into the output register as it moves on.
// - Throughput: one word per cycle while no stall holds it, set by the single
//   compare-and-capture step between the input register and the output register.
// - Stall: a word that yields no result keeps flowing while the output
//   holds an untaken item; a word that yields one waits in the input
//   register until the output register frees, and image_ready drops.
// - Reset (rst, synchronous): scan restarts at word 0 in scanning mode,
//   registers return to their defaults, both channels are empty.
//
module signature_record_extractor_core (
  input  logic                              clk,
  input  logic                              rst,
  // image word channel
  input  logic                              image_valid,
  output logic                              image_ready,
  input  logic [63:0]                       image_word,
  // record channel
  output logic                              record_valid,
  input  logic                              record_ready,
  output logic [sre_pkg::ADDR_BITS-1:0]     record_address,
  output logic [31:0]                       process_id,
  output logic [31:0]                       parent_id,
  output logic [63:0]                       name_low,
  output logic [63:0]                       name_high,
  // configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [sre_pkg::PADDR_BITS-1:0]    paddr,
  input  logic [63:0]                       pwdata,
  output logic [63:0]                       prdata,
  output logic                              pready
);
  import sre_pkg::*;

  `include "signature_record_extractor_core_assert.svh"

  sre_cfg_t    cfg;
  sre_result_t res;
  sre_status_t status;
  logic        res_valid;

  // input register
  logic        s1_valid;
  logic [63:0] s1_word;
  logic        s1_go;
  logic        step;

  sre_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  sre_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .word      (s1_word),
    .step      (step),
    .res_valid (res_valid),
    .res       (res),
    .status    (status)
  );

  // The held word may move on unless it makes a result and the output
  // register is still occupied by an item nobody has taken.
  assign s1_go       = !s1_valid || !res_valid || !record_valid || record_ready;
  assign step        = s1_valid && s1_go;
  assign image_ready = s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_go) begin
      s1_valid <= image_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && image_valid) begin
      s1_word <= image_word;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      record_valid <= 1'b0;
    end else if (step && res_valid) begin
      record_valid <= 1'b1;
    end else if (record_ready) begin
      record_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res_valid) begin
      record_address <= res.record_address;
      process_id     <= res.process_id;
      parent_id      <= res.parent_id;
      name_low       <= res.name_low;
      name_high      <= res.name_high;
    end
  end

  // a result only comes from inside an open record
  `SRE_ASSERT(a_result_in_record, !(s1_valid && res_valid) || status.in_record)
  // scanning always leaves the record offset cleared
  `SRE_ASSERT(a_offset_clear_scan, status.in_record || (status.record_offset == 8'd0))
  // a blocked word stays put in the input register
  `SRE_ASSERT_NEXT(a_blocked_word_held, s1_valid && !s1_go,
                   s1_valid && $stable(s1_word))

endmodule
